>>> hw/rtl/uros_pkg.sv
// Shared types and constants of the upload/render overlap scheduler.
`default_nettype none

package uros_pkg;

  localparam int MAX_GROUPS  = 64;
  localparam int VRAM_BLOCKS = 16384;

  localparam int IDX_W  = $clog2(MAX_GROUPS);
  localparam int CUR_W  = $clog2(MAX_GROUPS + 1);
  localparam int LO_W   = $clog2(VRAM_BLOCKS);
  localparam int HI_W   = $clog2(VRAM_BLOCKS + 1);
  localparam int CFG_IW = 1;
  localparam int CFG_DW = CUR_W;

  localparam logic [CFG_IW-1:0] REG_FIELD       = 1'd0;
  localparam logic [CFG_IW-1:0] REG_GROUP_COUNT = 1'd1;

  localparam logic [CUR_W-1:0] CUR_NONE = CUR_W'(MAX_GROUPS);

  typedef enum logic [1:0] {
    FUNC_LOAD,
    FUNC_START,
    FUNC_UPLOAD_DONE,
    FUNC_RENDER_DONE
  } func_t;

  typedef logic [CUR_W-1:0] cursor_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    func_t             func;
    idx_t              entry_index;
    logic [1:0]        used_mask;
    logic [LO_W-1:0]   vram_start;
    logic [HI_W-1:0]   vram_end;
  } item_t;

  typedef struct packed {
    logic [1:0]      used;
    logic [LO_W-1:0] lo;
    logic [HI_W-1:0] hi;
  } entry_t;

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    entry_t wdata;
    idx_t   raddr;
  } tbl_req_t;

  typedef struct packed {
    logic kick_upload;
    idx_t upload_group;
    logic kick_render;
    idx_t render_group;
    logic upload_valid;
    logic render_valid;
    logic upload_stalled;
    logic render_stalled;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/uros_if.sv
// Valid/ready channel interfaces for input items and results.
`default_nettype none

interface uros_item_if;
  logic                           valid;
  logic                           ready;
  uros_pkg::func_t                func;
  logic [uros_pkg::IDX_W-1:0]     entry_index;
  logic [1:0]                     used_mask;
  logic [uros_pkg::LO_W-1:0]      vram_start;
  logic [uros_pkg::HI_W-1:0]      vram_end;

  modport source (output valid, func, entry_index, used_mask, vram_start, vram_end,
                  input ready);
  modport sink (input valid, func, entry_index, used_mask, vram_start, vram_end,
                output ready);
endinterface

interface uros_result_if;
  logic                       valid;
  logic                       ready;
  logic                       kick_upload;
  logic [uros_pkg::IDX_W-1:0] upload_group;
  logic                       kick_render;
  logic [uros_pkg::IDX_W-1:0] render_group;
  logic                       upload_valid;
  logic                       render_valid;
  logic                       upload_stalled;
  logic                       render_stalled;

  modport source (output valid, kick_upload, upload_group, kick_render, render_group,
                  upload_valid, render_valid, upload_stalled, render_stalled,
                  input ready);
  modport sink (input valid, kick_upload, upload_group, kick_render, render_group,
                upload_valid, render_valid, upload_stalled, render_stalled,
                output ready);
endinterface

`default_nettype wire

>>> hw/rtl/upload_render_overlap_scheduler_top.sv
// Load/start items and done events on an invalid cursor go straight to the result;
// other done events first walk the table, then read both cursors' entries and decide.
// One item is in flight at a time: the next is taken once the result has moved into
// the output register, while the previous result may still wait there.
// Synchronous active-low reset clears cursors to none, wait flags and config registers
// to 0; the group table is not cleared.
`default_nettype none

module upload_render_overlap_scheduler_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  uros_item_if.sink                          in_ch,
  uros_result_if.source                      out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [uros_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [uros_pkg::CFG_DW-1:0]   cfg_wdata
);

  logic                     field_r;
  logic [uros_pkg::CUR_W-1:0] gcount_r;
  uros_pkg::cursor_t        list_len;

  uros_pkg::item_t          item;
  uros_pkg::tbl_req_t       tbl_req;
  uros_pkg::entry_t         tbl_rdata;
  uros_pkg::result_t        res;
  logic                     res_valid, res_taken;

  logic                     out_valid_r, out_valid_nxt;
  uros_pkg::result_t        out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r  <= 1'b0;
      gcount_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        uros_pkg::REG_FIELD:       field_r  <= cfg_wdata[0];
        uros_pkg::REG_GROUP_COUNT: gcount_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign list_len = (gcount_r > uros_pkg::CUR_NONE) ? uros_pkg::CUR_NONE : gcount_r;

  always_comb begin
    item.func        = in_ch.func;
    item.entry_index = in_ch.entry_index;
    item.used_mask   = in_ch.used_mask;
    item.vram_start  = in_ch.vram_start;
    item.vram_end    = in_ch.vram_end;
  end

  uros_table u_table (
    .clk   (clk),
    .req   (tbl_req),
    .rdata (tbl_rdata)
  );

  uros_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_item   (item),
    .in_ready  (in_ch.ready),
    .cfg_field (field_r),
    .list_len  (list_len),
    .tbl_req   (tbl_req),
    .tbl_rdata (tbl_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_taken (res_taken)
  );

  // load the output register when it is empty or being drained
  assign res_taken = res_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_taken) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_taken) begin
      out_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kick_upload    = out_r.kick_upload;
  assign out_ch.upload_group   = out_r.upload_group;
  assign out_ch.kick_render    = out_r.kick_render;
  assign out_ch.render_group   = out_r.render_group;
  assign out_ch.upload_valid   = out_r.upload_valid;
  assign out_ch.render_valid   = out_r.render_valid;
  assign out_ch.upload_stalled = out_r.upload_stalled;
  assign out_ch.render_stalled = out_r.render_stalled;

endmodule

`default_nettype wire

>>> hw/rtl/uros_table.sv
// Group table memory: one write port, one read port with registered data.
`default_nettype none

module uros_table (
  input  wire logic               clk,
  input  wire uros_pkg::tbl_req_t req,
  output uros_pkg::entry_t        rdata
);

  uros_pkg::entry_t mem [uros_pkg::MAX_GROUPS];
  uros_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hw/rtl/uros_ctrl.sv
// Sequencer: cursor walk over the table, range reads and engine kick decision.
`default_nettype none

module uros_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire uros_pkg::item_t         in_item,
  output logic                         in_ready,
  input  wire logic                    cfg_field,
  input  wire uros_pkg::cursor_t       list_len,
  output uros_pkg::tbl_req_t           tbl_req,
  input  wire uros_pkg::entry_t        tbl_rdata,
  output logic                         res_valid,
  output uros_pkg::result_t            res,
  input  wire logic                    res_taken
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_RD_U,
    S_RD_R,
    S_DECIDE,
    S_RESULT
  } state_t;

  state_t                    state_r, state_nxt;
  uros_pkg::func_t           func_r, func_nxt;
  uros_pkg::cursor_t         ucur_r, ucur_nxt;
  uros_pkg::cursor_t         rcur_r, rcur_nxt;
  logic                      uwait_r, uwait_nxt;
  logic                      rwait_r, rwait_nxt;
  logic                      su_r, su_nxt;
  logic                      sr_r, sr_nxt;
  uros_pkg::cursor_t         issue_r, issue_nxt;
  uros_pkg::cursor_t         chk_r, chk_nxt;
  logic                      chk_vld_r, chk_vld_nxt;
  logic [uros_pkg::LO_W-1:0] ulo_r, ulo_nxt;
  logic [uros_pkg::HI_W-1:0] uhi_r, uhi_nxt;

  logic                      uv, rv, noconf;
  logic                      load_ok, start_ok;
  logic                      walk_end, walk_hit;
  uros_pkg::cursor_t         walk_pos;
  uros_pkg::entry_t          load_entry;

  assign uv = ucur_r < uros_pkg::CUR_NONE;
  assign rv = rcur_r < uros_pkg::CUR_NONE;
  // rdata holds the render cursor's entry in S_DECIDE
  assign noconf = !(uv && rv) ||
                  ({1'b0, tbl_rdata.lo} >= uhi_r) ||
                  ({1'b0, ulo_r} >= tbl_rdata.hi);

  assign load_ok  = uros_pkg::CUR_W'(in_item.entry_index) < uros_pkg::CUR_NONE;
  assign start_ok = uros_pkg::CUR_W'(in_item.entry_index) < list_len;

  assign walk_end = chk_r >= list_len;
  assign walk_hit = tbl_rdata.used[~cfg_field];
  assign walk_pos = walk_end ? uros_pkg::CUR_NONE : chk_r;

  always_comb begin
    load_entry.used = in_item.used_mask;
    load_entry.lo   = (in_item.vram_start > uros_pkg::LO_W'(uros_pkg::VRAM_BLOCKS - 1)) ?
                      uros_pkg::LO_W'(uros_pkg::VRAM_BLOCKS - 1) : in_item.vram_start;
    load_entry.hi   = (in_item.vram_end > uros_pkg::HI_W'(uros_pkg::VRAM_BLOCKS)) ?
                      uros_pkg::HI_W'(uros_pkg::VRAM_BLOCKS) : in_item.vram_end;
  end

  always_comb begin
    state_nxt   = state_r;
    func_nxt    = func_r;
    ucur_nxt    = ucur_r;
    rcur_nxt    = rcur_r;
    uwait_nxt   = uwait_r;
    rwait_nxt   = rwait_r;
    su_nxt      = su_r;
    sr_nxt      = sr_r;
    issue_nxt   = issue_r;
    chk_nxt     = chk_r;
    chk_vld_nxt = chk_vld_r;
    ulo_nxt     = ulo_r;
    uhi_nxt     = uhi_r;

    tbl_req.we    = 1'b0;
    tbl_req.waddr = in_item.entry_index;
    tbl_req.wdata = load_entry;
    tbl_req.raddr = issue_r[uros_pkg::IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_item.func;
          su_nxt    = 1'b0;
          sr_nxt    = 1'b0;
          state_nxt = S_RESULT;
          unique case (in_item.func)
            uros_pkg::FUNC_LOAD: begin
              tbl_req.we = load_ok;
            end
            uros_pkg::FUNC_START: begin
              uwait_nxt = 1'b0;
              if (start_ok) begin
                ucur_nxt  = uros_pkg::CUR_W'(in_item.entry_index);
                rcur_nxt  = uros_pkg::CUR_W'(in_item.entry_index);
                rwait_nxt = 1'b1;
                su_nxt    = 1'b1;
              end else begin
                ucur_nxt  = uros_pkg::CUR_NONE;
                rcur_nxt  = uros_pkg::CUR_NONE;
                rwait_nxt = 1'b0;
              end
            end
            uros_pkg::FUNC_UPLOAD_DONE: begin
              if (uv) begin
                issue_nxt   = ucur_r + uros_pkg::CUR_W'(1);
                chk_vld_nxt = 1'b0;
                state_nxt   = S_WALK;
              end
            end
            uros_pkg::FUNC_RENDER_DONE: begin
              if (rv) begin
                issue_nxt   = rcur_r + uros_pkg::CUR_W'(1);
                chk_vld_nxt = 1'b0;
                state_nxt   = S_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        // one read issued per cycle; its data is checked in the next cycle
        chk_nxt     = issue_r;
        chk_vld_nxt = 1'b1;
        if (issue_r < list_len) begin
          issue_nxt = issue_r + uros_pkg::CUR_W'(1);
        end
        if (chk_vld_r && (walk_end || walk_hit)) begin
          if (func_r == uros_pkg::FUNC_UPLOAD_DONE) begin
            ucur_nxt = walk_pos;
          end else begin
            rcur_nxt = walk_pos;
          end
          state_nxt = S_RD_U;
        end
      end
      S_RD_U: begin
        tbl_req.raddr = ucur_r[uros_pkg::IDX_W-1:0];
        state_nxt     = S_RD_R;
      end
      S_RD_R: begin
        tbl_req.raddr = rcur_r[uros_pkg::IDX_W-1:0];
        ulo_nxt       = tbl_rdata.lo;
        uhi_nxt       = tbl_rdata.hi;
        state_nxt     = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_RESULT;
        if (func_r == uros_pkg::FUNC_UPLOAD_DONE) begin
          if (uv) begin
            if (rwait_r) begin
              sr_nxt    = rv;
              rwait_nxt = 1'b0;
              su_nxt    = noconf;
              uwait_nxt = !noconf;
            end else begin
              uwait_nxt = 1'b1;
            end
          end else if (rwait_r) begin
            sr_nxt    = rv;
            rwait_nxt = 1'b0;
          end
        end else if (rv) begin
          if (uwait_r) begin
            if (rcur_r == ucur_r) begin
              su_nxt    = 1'b1;
              uwait_nxt = 1'b0;
              rwait_nxt = 1'b1;
            end else begin
              sr_nxt    = 1'b1;
              rwait_nxt = 1'b0;
              if (noconf) begin
                su_nxt    = uv;
                uwait_nxt = 1'b0;
              end
            end
          end else if (uv) begin
            rwait_nxt = 1'b1;
          end else begin
            sr_nxt    = 1'b1;
            rwait_nxt = 1'b0;
          end
        end
      end
      S_RESULT: begin
        if (res_taken) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ucur_r    <= uros_pkg::CUR_NONE;
      rcur_r    <= uros_pkg::CUR_NONE;
      uwait_r   <= 1'b0;
      rwait_r   <= 1'b0;
      chk_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ucur_r    <= ucur_nxt;
      rcur_r    <= rcur_nxt;
      uwait_r   <= uwait_nxt;
      rwait_r   <= rwait_nxt;
      chk_vld_r <= chk_vld_nxt;
    end
    func_r  <= func_nxt;
    su_r    <= su_nxt;
    sr_r    <= sr_nxt;
    issue_r <= issue_nxt;
    chk_r   <= chk_nxt;
    ulo_r   <= ulo_nxt;
    uhi_r   <= uhi_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESULT);

  always_comb begin
    res.kick_upload    = su_r;
    res.upload_group   = uv ? ucur_r[uros_pkg::IDX_W-1:0] : '0;
    res.kick_render    = sr_r;
    res.render_group   = rv ? rcur_r[uros_pkg::IDX_W-1:0] : '0;
    res.upload_valid   = uv;
    res.render_valid   = rv;
    res.upload_stalled = uwait_r;
    res.render_stalled = rwait_r;
  end

endmodule

`default_nettype wire
